>>> sv/kmd_pkg.sv
// Shared constants, types and register codes for the key matrix debouncer.
`timescale 1ns / 1ps
package kmd_pkg;

  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 3;
  localparam int SLOT_COUNT   = 6;

  localparam int MATRIX_KEYS = ROW_COUNT * COLUMN_COUNT;
  localparam int MAPPED_KEYS = 12;
  // keys past the mapped set always read released and never show
  localparam int LANE_COUNT  = (MATRIX_KEYS < MAPPED_KEYS) ? MATRIX_KEYS : MAPPED_KEYS;
  localparam int SLOT_MAX    = 6;
  localparam int RANK_W      = $clog2(LANE_COUNT + 1);

  localparam int CODE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int KEYMAP_W    = MAPPED_KEYS * CODE_W;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [4:0] MOD_PREFIX = 5'b11100;  // upper bits of 0xE0..0xE7
  localparam logic [2:0] MOD_TOP    = 3'b111;    // 0xE0 and above

  localparam int IN_W  = 16;
  localparam int OUT_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYMAP_LOW  = 2'd0,
    REG_KEYMAP_HIGH = 2'd1,
    REG_THRESHOLD   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              settled_next;
    logic              slot_req;
    logic [CODE_W-1:0] code;
    logic [7:0]        mod_mask;
  } lane_t;

  typedef struct packed {
    logic [MAPPED_KEYS-1:0]         debounced;
    logic [SLOT_MAX-1:0][CODE_W-1:0] slots;
    logic [7:0]                     modifiers;
  } report_t;

endpackage

>>> sv/kmd_lane.sv
// One key lane: saturating debounce counter and keycode classification.
`timescale 1ns / 1ps
module kmd_lane
  import kmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              level,
  input  logic [CNT_W-1:0]  threshold,
  input  logic [CODE_W-1:0] code,
  output lane_t             lane
);

  logic             last_level;
  logic             settled;
  logic [CNT_W-1:0] stable_count;

  logic             last_level_next;
  logic             settled_next;
  logic [CNT_W-1:0] stable_count_next;

  always_comb begin
    last_level_next   = last_level;
    settled_next      = settled;
    stable_count_next = stable_count;
    if (level == last_level) begin
      if (stable_count < threshold) begin
        stable_count_next = stable_count + CNT_W'(1);
      end
      if (stable_count_next >= threshold) begin
        settled_next = level;
      end
    end else begin
      stable_count_next = '0;
      last_level_next   = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      settled      <= 1'b0;
      stable_count <= '0;
    end else if (en) begin
      last_level   <= last_level_next;
      settled      <= settled_next;
      stable_count <= stable_count_next;
    end
  end

  // slots and modifiers use the raw level; 0xE8..0xFF set no bit and take no slot
  always_comb begin
    lane.settled_next = settled_next;
    lane.code         = code;
    lane.slot_req     = level && (code[7:5] != MOD_TOP);
    lane.mod_mask     = (level && (code[7:3] == MOD_PREFIX)) ? (8'd1 << code[2:0]) : 8'd0;
  end

endmodule

>>> sv/kmd_merge.sv
// Merges the lane results: modifier OR, slot compaction, debounced vector.
`timescale 1ns / 1ps
module kmd_merge
  import kmd_pkg::*;
(
  input  lane_t   lanes [LANE_COUNT],
  output report_t report
);

  logic [LANE_COUNT-1:0] req;
  logic [RANK_W-1:0]     rank [LANE_COUNT];

  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      req[k] = lanes[k].slot_req;
    end
  end

  // rank of each lane among the requesting lanes below it
  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      rank[k] = '0;
      for (int i = 0; i < k; i++) begin
        rank[k] = rank[k] + RANK_W'(req[i]);
      end
    end
  end

  always_comb begin
    report = '0;
    for (int k = 0; k < LANE_COUNT; k++) begin
      report.modifiers    = report.modifiers | lanes[k].mod_mask;
      report.debounced[k] = lanes[k].settled_next;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (req[k] && (rank[k] == RANK_W'(j))) begin
          report.slots[j] = report.slots[j] | lanes[k].code;
        end
      end
    end
  end

endmodule

>>> sv/key_matrix_debounce_hid_report.sv
// Top level: key matrix debouncer and boot keyboard report builder.
//
// Usage:
//   s_* channel: one request per matrix scan, s_tdata[11:0] = raw_keys
//   (bit row*3+col set when pressed), upper bits zero.
//   m_* channel: one request per scan: modifier byte, six keycode slots and
//   the debounced key levels.
//   cfg_*: write-only register port; cfg_index selects keymap_low,
//   keymap_high or stable_threshold, taken on any edge with cfg_we high.
//   Write it only while no scan is in flight.
// Output: the result is registered and valid in the cycle after the scan is accepted.
// Throughput: one scan per cycle while the output is not stalled; twelve key
//   lanes run side by side and the merge logic (slot ranking and select) sits
//   before a single output register.
// Stall: with the output register full and m_tready low, s_tready drops;
//   debounce state only moves on an accepted scan, so nothing is lost.
// Reset: rst (synchronous) empties the output register, clears every key
//   counter and level, zeroes the keymap and sets the threshold to 5.
`timescale 1ns / 1ps
module key_matrix_debounce_hid_report
  import kmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // scan input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // [11:0] raw_keys, [15:12] zero
  // report output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // [7:0] modifier_bits, [15:8] slot_zero,
                                          // [23:16] slot_one, [31:24] slot_two,
                                          // [39:32] slot_three, [47:40] slot_four,
                                          // [55:48] slot_five, [67:56] debounced_keys,
                                          // [71:68] zero
);

  logic [63:0]      keymap_low;
  logic [31:0]      keymap_high;
  logic [CNT_W-1:0] stable_threshold;

  logic [KEYMAP_W-1:0] keymap;
  logic                accept;
  lane_t               lanes [LANE_COUNT];
  report_t             report;
  report_t             out_report;
  logic                out_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keymap_low       <= '0;
      keymap_high      <= '0;
      stable_threshold <= CNT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEYMAP_LOW:  keymap_low       <= cfg_data;
        REG_KEYMAP_HIGH: keymap_high      <= cfg_data[31:0];
        REG_THRESHOLD:   stable_threshold <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign keymap = {keymap_high, keymap_low};

  // output register frees up when empty or being drained
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // one debounce/classify lane per key
  for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
    kmd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .en        (accept),
      .level     (s_tdata[k]),
      .threshold (stable_threshold),
      .code      (keymap[k*CODE_W +: CODE_W]),
      .lane      (lanes[k])
    );
  end

  kmd_merge u_merge (
    .lanes  (lanes),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_report <= report;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - $bits(report_t))'(0), out_report};

endmodule

>>> sv/kmd_checker.sv
// Port-level checks for the key matrix debouncer, bound to the top level.
`timescale 1ns / 1ps
module kmd_checker
  import kmd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  // no report is held after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("report valid right after reset");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // every accepted scan shows a report on the next cycle
  a_scan_report: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted scan gave no report");

  // slots never carry modifier-range codes
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:13] != MOD_TOP) && (m_tdata[23:21] != MOD_TOP) &&
                 (m_tdata[31:29] != MOD_TOP) && (m_tdata[39:37] != MOD_TOP) &&
                 (m_tdata[47:45] != MOD_TOP) && (m_tdata[55:53] != MOD_TOP))
    else $error("modifier keycode placed in a slot");

  // stalled report holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled report changed");

endmodule

bind key_matrix_debounce_hid_report kmd_checker u_kmd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
